// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include guarded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

// File: rtl/tsoc_pkg.sv
// Package of the three-site overlap check: widths, register indexes, opcodes.
// Depends on nothing.
package tsoc_pkg;
	localparam int MaxMolecules = 1024;
	localparam int CoordWidth = 24;
	localparam int CfgWidth = 48;
	localparam int CountWidth = 11;
	localparam int IndexWidth = 10;
	localparam int CfgIndexWidth = 3;

	localparam logic [CfgIndexWidth-1:0] RegCount = 3'd0;
	localparam logic [CfgIndexWidth-1:0] RegBox = 3'd1;
	localparam logic [CfgIndexWidth-1:0] RegCutHH = 3'd2;
	localparam logic [CfgIndexWidth-1:0] RegCutHL1 = 3'd3;
	localparam logic [CfgIndexWidth-1:0] RegCutHL2 = 3'd4;
	localparam logic [CfgIndexWidth-1:0] RegCutL1L1 = 3'd5;
	localparam logic [CfgIndexWidth-1:0] RegCutL1L2 = 3'd6;
	localparam logic [CfgIndexWidth-1:0] RegCutL2L2 = 3'd7;

	localparam logic OpLoad = 1'b0;
	localparam logic OpCheck = 1'b1;
endpackage

// File: rtl/tsoc_dist.sv
// One pipelined squared minimum-image distance unit with cutoff compare.
// Depends on tsoc_pkg for the default COORD_WIDTH; widths follow COORD_WIDTH.
module tsoc_dist #(
	parameter int COORD_WIDTH = tsoc_pkg::CoordWidth
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [3*COORD_WIDTH-1:0]   a,
	input  logic [3*COORD_WIDTH-1:0]   b,
	input  logic [COORD_WIDTH-2:0]     box,
	input  logic [2*COORD_WIDTH-1:0]   cut,
	output logic                       close
);
	localparam int DW = COORD_WIDTH + 2;
	localparam int SW = 2 * DW;

	logic signed [DW-1:0] d_s1 [3];
	logic [2*COORD_WIDTH-1:0] cut_s1, cut_s2, cut_s3;
	logic [SW-1:0] sq_s2 [3];
	logic [SW+1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [DW-1:0] av, bv, d, d2, len;
				av = DW'(signed'(a[k*COORD_WIDTH +: COORD_WIDTH]));
				bv = DW'(signed'(b[k*COORD_WIDTH +: COORD_WIDTH]));
				len = signed'(DW'(box));
				d = bv - av;
				d2 = d <<< 1;
				if (box == '0) d_s1[k] <= d;
				else if (d2 >= len) d_s1[k] <= d - len;
				else if (d2 <= -len) d_s1[k] <= d + len;
				else d_s1[k] <= d;
			end
			cut_s1 <= cut;
			for (int k = 0; k < 3; k++) begin
				logic [DW-1:0] m;
				m = d_s1[k][DW-1] ? DW'(-d_s1[k]) : DW'(d_s1[k]);
				sq_s2[k] <= m * m;
			end
			cut_s2 <= cut_s1;
			sum_s3 <= (SW+2)'(sq_s2[0]) + (SW+2)'(sq_s2[1]) + (SW+2)'(sq_s2[2]);
			cut_s3 <= cut_s2;
			close <= sum_s3 < (SW+2)'(cut_s3);
		end
	end
endmodule

// File: rtl/tsoc_store.sv
// Coordinate memory: one slot of nine coordinates per word, registered read.
// Depends on tsoc_pkg for defaults.
module tsoc_store #(
	parameter int MAX_MOLECULES = tsoc_pkg::MaxMolecules,
	parameter int COORD_WIDTH = tsoc_pkg::CoordWidth,
	localparam int AW = $clog2(MAX_MOLECULES)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [9*COORD_WIDTH-1:0] wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [9*COORD_WIDTH-1:0] rdata
);
	logic [9*COORD_WIDTH-1:0] mem_q [MAX_MOLECULES];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/three_site_overlap_check_top.sv
// Top level of the three-site overlap check: registers, sequencer, twelve units.
// Depends on tsoc_pkg, tsoc_store and tsoc_dist.
//
// channel | signals                                   | handshake
// input   | operation mol_index h_* l1_* l2_*         | start and not busy
// config  | cfg_we cfg_index cfg_data                 | cfg_we
// result  | conflict                                  | done, one cycle
//
// A check scans molecule_count stored molecules, with molecule_count capped at
// the table size: the memory read port
// gives one stored molecule per cycle to nine distance units.
// busy goes high after a check is accepted and is low again in its done cycle.
// arst_n resets the registers (box to 4096) and the sequencer; the memory is not cleared.
// The receiver cannot stall; done is shown for one cycle.
module three_site_overlap_check_top #(
	parameter int MAX_MOLECULES = tsoc_pkg::MaxMolecules,
	parameter int COORD_WIDTH = tsoc_pkg::CoordWidth
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [tsoc_pkg::IndexWidth-1:0]     mol_index,
	input  logic signed [COORD_WIDTH-1:0]       h_x, h_y, h_z,
	input  logic signed [COORD_WIDTH-1:0]       l1_x, l1_y, l1_z,
	input  logic signed [COORD_WIDTH-1:0]       l2_x, l2_y, l2_z,
	input  logic                                cfg_we,
	input  logic [tsoc_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [2*COORD_WIDTH-1:0]            cfg_data,
	output logic                                done,
	output logic                                conflict
);
	localparam int AW = $clog2(MAX_MOLECULES);
	localparam int CW = 3 * COORD_WIDTH;
	localparam int NW = AW + 1;
	localparam int Lat = 4;

	typedef enum logic [1:0] {Idle, Scan, Drain, Finish} state_t;
	state_t state_q;

	logic [tsoc_pkg::CountWidth-1:0] count_q;
	logic [COORD_WIDTH-2:0] box_q;
	logic [2*COORD_WIDTH-1:0] cut_q [6];
	logic [CW-1:0] cand_q [3];
	logic [tsoc_pkg::IndexWidth-1:0] self_q;
	logic [NW-1:0] ptr_q, lim_q;
	logic [2:0] drain_q;
	logic hit_q;
	logic [Lat-1:0] vld_q;
	logic [9*COORD_WIDTH-1:0] rdata;
	logic [8:0] close_m;
	logic [2:0] close_i;

	logic accept;
	logic rd_en;
	logic [CW-1:0] in_site [3];
	assign accept = start && !busy;
	assign busy = state_q != Idle;
	assign in_site[0] = {h_z, h_y, h_x};
	assign in_site[1] = {l1_z, l1_y, l1_x};
	assign in_site[2] = {l2_z, l2_y, l2_x};
	assign rd_en = state_q == Scan && ptr_q < lim_q;

	function automatic int pair_of(input int s, input int t);
		int lo, hi;
		lo = (s < t) ? s : t;
		hi = (s < t) ? t : s;
		if (lo == 0) return hi;
		if (lo == 1) return 2 + hi;
		return 5;
	endfunction

	tsoc_store #(.MAX_MOLECULES(MAX_MOLECULES), .COORD_WIDTH(COORD_WIDTH)) u_store (
		.clk(clk),
		.we(accept && operation == tsoc_pkg::OpLoad && 32'(mol_index) < MAX_MOLECULES),
		.waddr(AW'(mol_index)),
		.wdata({in_site[2], in_site[1], in_site[0]}),
		.re(rd_en),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	logic rv_s1;
	logic [NW-1:0] rptr_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			rptr_s1 <= '0;
		end else begin
			rv_s1 <= rd_en;
			rptr_s1 <= ptr_q;
		end
	end

	for (genvar s = 0; s < 3; s++) begin : g_s
		for (genvar t = 0; t < 3; t++) begin : g_t
			tsoc_dist #(.COORD_WIDTH(COORD_WIDTH)) u_d (
				.clk(clk), .en(1'b1), .a(cand_q[s]),
				.b(rdata[t*CW +: CW]), .box(box_q),
				.cut(cut_q[pair_of(s, t)]), .close(close_m[s*3+t])
			);
		end
	end
	for (genvar p = 0; p < 3; p++) begin : g_i
		localparam int PA = (p == 2) ? 1 : 0;
		localparam int PB = (p == 0) ? 1 : 2;
		tsoc_dist #(.COORD_WIDTH(COORD_WIDTH)) u_d (
			.clk(clk), .en(1'b1), .a(cand_q[PA]), .b(cand_q[PB]), .box(box_q),
			.cut(cut_q[pair_of(PA, PB)]), .close(close_i[p])
		);
	end

	logic skip_s1;
	assign skip_s1 = rptr_s1 == NW'(self_q) && 32'(self_q) < MAX_MOLECULES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			box_q <= (COORD_WIDTH-1)'(4096);
			for (int i = 0; i < 6; i++) cut_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsoc_pkg::RegCount: count_q <= cfg_data[tsoc_pkg::CountWidth-1:0];
				tsoc_pkg::RegBox: box_q <= cfg_data[COORD_WIDTH-2:0];
				tsoc_pkg::RegCutHH: cut_q[0] <= cfg_data;
				tsoc_pkg::RegCutHL1: cut_q[1] <= cfg_data;
				tsoc_pkg::RegCutHL2: cut_q[2] <= cfg_data;
				tsoc_pkg::RegCutL1L1: cut_q[3] <= cfg_data;
				tsoc_pkg::RegCutL1L2: cut_q[4] <= cfg_data;
				tsoc_pkg::RegCutL2L2: cut_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Idle;
			ptr_q <= '0;
			lim_q <= '0;
			drain_q <= '0;
			hit_q <= 1'b0;
			vld_q <= '0;
			done <= 1'b0;
			conflict <= 1'b0;
			self_q <= '0;
			for (int i = 0; i < 3; i++) cand_q[i] <= '0;
		end else begin
			done <= 1'b0;
			vld_q <= {vld_q[Lat-2:0], rv_s1 && !skip_s1};
			if (vld_q[Lat-1] && |close_m) hit_q <= 1'b1;
			unique case (state_q)
				Idle: begin
					if (accept && operation == tsoc_pkg::OpCheck) begin
						for (int i = 0; i < 3; i++) cand_q[i] <= in_site[i];
						self_q <= mol_index;
						ptr_q <= '0;
						lim_q <= (32'(count_q) > MAX_MOLECULES) ? NW'(MAX_MOLECULES)
							: NW'(count_q);
						hit_q <= 1'b0;
						drain_q <= '0;
						state_q <= Scan;
					end
				end
				Scan: begin
					if (rd_en) ptr_q <= ptr_q + NW'(1);
					else begin
						drain_q <= '0;
						state_q <= Drain;
					end
				end
				Drain: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == 3'd6) state_q <= Finish;
				end
				Finish: begin
					done <= 1'b1;
					conflict <= hit_q || (|close_i);
					state_q <= Idle;
				end
				default: state_q <= Idle;
			endcase
		end
	end
endmodule

// File: rtl/tsoc_checker.sv
// Port-level checker of the overlap check, bound to the top level.
// Depends on assert_macros.svh and tsoc_pkg.
`include "assert_macros.svh"
module tsoc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic done
);
	`CHK_IMPL(a_check_busy, clk, arst_n, start && !busy && operation == tsoc_pkg::OpCheck, ##1 busy, "check did not raise busy")
	`CHK_IMPL(a_load_idle, clk, arst_n, start && !busy && operation == tsoc_pkg::OpLoad, ##1 !busy, "load raised busy")
	`CHK_IMPL(a_done_pulse, clk, arst_n, done, ##1 !done, "done longer than one cycle")
	`CHK_IMPL(a_done_end, clk, arst_n, done, !busy && $past(busy), "done outside a check")
endmodule

bind three_site_overlap_check_top tsoc_checker u_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.operation(operation), .done(done)
);
